// File: src/mmdoam_pkg.sv
// Shared types and constants for the memory map decoder with object RAM DMA.
package mmdoam_pkg;

  // Request codes
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Target unit codes
  localparam logic [3:0] UNIT_NONE  = 4'd0;
  localparam logic [3:0] UNIT_ROM   = 4'd1;
  localparam logic [3:0] UNIT_VRAM  = 4'd2;
  localparam logic [3:0] UNIT_CRAM  = 4'd3;
  localparam logic [3:0] UNIT_WRAM  = 4'd4;
  localparam logic [3:0] UNIT_OAM   = 4'd5;
  localparam logic [3:0] UNIT_JOYP  = 4'd6;
  localparam logic [3:0] UNIT_TIMER = 4'd7;
  localparam logic [3:0] UNIT_IRQ   = 4'd8;
  localparam logic [3:0] UNIT_LCD   = 4'd9;
  localparam logic [3:0] UNIT_HRAM  = 4'd10;
  localparam logic [3:0] UNIT_DMA   = 4'd11;

  // Address map boundaries
  localparam logic [15:0] ROM_LAST   = 16'h7FFF;
  localparam logic [15:0] VRAM_LAST  = 16'h9FFF;
  localparam logic [15:0] CRAM_LAST  = 16'hBFFF;
  localparam logic [15:0] WRAM_LAST  = 16'hDFFF;
  localparam logic [15:0] ECHO_LAST  = 16'hFDFF;
  localparam logic [15:0] OAM_LAST   = 16'hFE9F;
  localparam logic [15:0] UNUSE_LAST = 16'hFEFF;
  localparam logic [15:0] JOYP_ADDR  = 16'hFF00;
  localparam logic [15:0] TIMER_LO   = 16'hFF04;
  localparam logic [15:0] TIMER_HI   = 16'hFF07;
  localparam logic [15:0] IF_ADDR    = 16'hFF0F;
  localparam logic [15:0] LCD_LO     = 16'hFF40;
  localparam logic [15:0] LCD_HI     = 16'hFF4B;
  localparam logic [15:0] DMA_ADDR   = 16'hFF46;
  localparam logic [15:0] IO_LAST    = 16'hFF7F;
  localparam logic [15:0] HRAM_LAST  = 16'hFFFE;

  localparam logic [7:0] DMA_LAST_BYTE = 8'h9F;
  localparam logic [8:0] DMA_STALL     = 9'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
  } bus_req_t;

  typedef struct packed {
    logic [3:0]  target_unit;
    logic [14:0] unit_offset;
    logic        is_write;
    logic [7:0]  data_out;
    logic [7:0]  local_data;
    logic        is_dma_copy;
    logic [7:0]  oam_index;
  } bus_rsp_t;

endpackage

// File: src/memory_map_decoder_with_oam_dma.sv
// Memory map decoder with object RAM DMA: one bus beat in, at most one routed beat out.
//
// Each accepted beat (read, write or tick) is decoded combinationally and its result, if any,
// is registered for the output; one beat can be accepted every cycle while the skid register
// is empty. Decoding is the single stage between the input and the output register;
// a skid register behind the output register keeps input accepting for one beat while a
// result is stalled. A write to 0xFF46 starts a DMA: the first copy command is returned
// for that write, each later one for the first tick that finds no stall pending.
module memory_map_decoder_with_oam_dma (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  mmdoam_pkg::bus_req_t req_i,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output mmdoam_pkg::bus_rsp_t rsp_o
);

  typedef struct packed {
    logic [3:0]  unit;
    logic [14:0] offset;
    logic [7:0]  loc;
  } route_t;

  // Map an address onto a unit and a local offset.
  function automatic route_t route(input logic [15:0] a, input logic [7:0] page);
    route_t r;
    r = '0;
    priority if (a <= mmdoam_pkg::ROM_LAST) begin
      r.unit   = mmdoam_pkg::UNIT_ROM;
      r.offset = a[14:0];
    end else if (a <= mmdoam_pkg::VRAM_LAST) begin
      r.unit   = mmdoam_pkg::UNIT_VRAM;
      r.offset = {2'b00, a[12:0]};
    end else if (a <= mmdoam_pkg::CRAM_LAST) begin
      r.unit   = mmdoam_pkg::UNIT_CRAM;
      r.offset = {2'b00, a[12:0]};
    end else if (a <= mmdoam_pkg::ECHO_LAST) begin
      // work RAM and its echo share the low 13 bits
      r.unit   = mmdoam_pkg::UNIT_WRAM;
      r.offset = {2'b00, a[12:0]};
    end else if (a <= mmdoam_pkg::OAM_LAST) begin
      r.unit   = mmdoam_pkg::UNIT_OAM;
      r.offset = {7'd0, a[7:0]};
    end else if (a <= mmdoam_pkg::UNUSE_LAST) begin
      r.unit = mmdoam_pkg::UNIT_NONE;
    end else if (a == mmdoam_pkg::JOYP_ADDR) begin
      r.unit = mmdoam_pkg::UNIT_JOYP;
    end else if (a >= mmdoam_pkg::TIMER_LO && a <= mmdoam_pkg::TIMER_HI) begin
      r.unit   = mmdoam_pkg::UNIT_TIMER;
      r.offset = {13'd0, a[1:0]};
    end else if (a == mmdoam_pkg::IF_ADDR) begin
      r.unit = mmdoam_pkg::UNIT_IRQ;
    end else if (a == mmdoam_pkg::DMA_ADDR) begin
      r.unit = mmdoam_pkg::UNIT_DMA;
      r.loc  = page;
    end else if (a >= mmdoam_pkg::LCD_LO && a <= mmdoam_pkg::LCD_HI) begin
      r.unit   = mmdoam_pkg::UNIT_LCD;
      r.offset = {11'd0, a[3:0]};
    end else if (a <= mmdoam_pkg::IO_LAST) begin
      r.unit = mmdoam_pkg::UNIT_NONE;
    end else if (a <= mmdoam_pkg::HRAM_LAST) begin
      r.unit   = mmdoam_pkg::UNIT_HRAM;
      r.offset = {8'd0, a[6:0]};
    end else begin
      r.unit   = mmdoam_pkg::UNIT_IRQ;
      r.offset = 15'd1;
    end
    return r;
  endfunction

  logic                 dma_active_q, dma_active_d;
  logic [15:0]          dma_src_q, dma_src_d;
  logic [7:0]           stall_q, stall_d;
  logic                 out_vld_q, skid_vld_q;
  mmdoam_pkg::bus_rsp_t out_q, skid_q;

  logic                 req_fire, rsp_fire;
  logic                 res_vld;
  mmdoam_pkg::bus_rsp_t res;
  logic                 do_copy, dma_start;
  logic [15:0]          copy_src;
  logic [8:0]           stall_sum;
  route_t               acc_rt, copy_rt;

  assign req_ready_o = !skid_vld_q;
  assign req_fire    = req_valid_i && req_ready_o;
  assign rsp_valid_o = out_vld_q;
  assign rsp_o       = out_q;
  assign rsp_fire    = out_vld_q && rsp_ready_i;

  assign dma_start = (req_i.req_type == mmdoam_pkg::REQ_WRITE) &&
                     (req_i.address == mmdoam_pkg::DMA_ADDR);
  assign copy_src  = dma_start ? {req_i.write_data, 8'h00} : dma_src_q;
  assign acc_rt    = route(req_i.address, dma_src_q[15:8]);
  assign copy_rt   = route(copy_src, copy_src[15:8]);
  assign stall_sum = {1'b0, stall_q} + mmdoam_pkg::DMA_STALL;

  always_comb begin
    do_copy      = 1'b0;
    res_vld      = 1'b0;
    res          = '0;
    dma_active_d = dma_active_q;
    dma_src_d    = dma_src_q;
    stall_d      = stall_q;

    unique case (req_i.req_type)
      mmdoam_pkg::REQ_READ, mmdoam_pkg::REQ_WRITE: begin
        res_vld = 1'b1;
        if (dma_start) begin
          do_copy      = 1'b1;
          dma_active_d = 1'b1;
        end else begin
          res.target_unit = acc_rt.unit;
          res.unit_offset = acc_rt.offset;
          res.local_data  = acc_rt.loc;
          res.is_write    = (req_i.req_type == mmdoam_pkg::REQ_WRITE) &&
                            (acc_rt.unit != mmdoam_pkg::UNIT_NONE);
          res.data_out    = res.is_write ? req_i.write_data : 8'h00;
        end
      end
      mmdoam_pkg::REQ_TICK: begin
        if (stall_q != 8'd0) begin
          stall_d = stall_q - 8'd1;
        end else if (dma_active_q) begin
          do_copy = 1'b1;
          res_vld = 1'b1;
        end
      end
      default: ;
    endcase

    if (do_copy) begin
      res.target_unit = copy_rt.unit;
      res.unit_offset = copy_rt.offset;
      res.local_data  = copy_rt.loc;
      res.is_dma_copy = 1'b1;
      res.oam_index   = copy_src[7:0];
      if (copy_src[7:0] == mmdoam_pkg::DMA_LAST_BYTE) begin
        dma_active_d = 1'b0;
        dma_src_d    = copy_src;
      end else begin
        dma_src_d = copy_src + 16'd1;
        stall_d   = stall_sum[8] ? 8'hFF : stall_sum[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dma_active_q <= 1'b0;
      dma_src_q    <= 16'h0000;
      stall_q      <= 8'h00;
    end else if (req_fire) begin
      dma_active_q <= dma_active_d;
      dma_src_q    <= dma_src_d;
      stall_q      <= stall_d;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (rsp_fire) begin
        skid_vld_q <= 1'b0;
      end
    end else if (req_fire && res_vld) begin
      if (!out_vld_q || rsp_fire) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (rsp_fire) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (rsp_fire) begin
        out_q <= skid_q;
      end
    end else if (req_fire && res_vld) begin
      if (!out_vld_q || rsp_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held without a result in the output register");

  a_oam_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.is_dma_copy |-> rsp_o.oam_index <= mmdoam_pkg::DMA_LAST_BYTE)
    else $error("DMA copy beyond the last object RAM byte");

  a_stall_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && req_i.req_type == mmdoam_pkg::REQ_TICK && stall_q != 8'd0
    |=> stall_q == $past(stall_q) - 8'd1)
    else $error("stall count did not count down on a tick");

  a_copy_needs_dma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && req_i.req_type == mmdoam_pkg::REQ_TICK && !dma_active_q
    |=> $stable(out_q) || $past(skid_vld_q) || !$past(out_vld_q) || $past(rsp_fire))
    else $error("idle tick produced a result");

endmodule
